FILE: hdl/sem_pkg.sv
package sem_pkg;

   localparam int MAX_WIDTH_DEF  = 1024;
   localparam int MAX_HEIGHT_DEF = 1024;

   localparam int PIX_W      = 24;
   localparam int CH_W       = 8;
   localparam int NUM_CH     = 3;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 11;
   localparam int WIDTH_RST  = 640;
   localparam int HEIGHT_RST = 480;

   localparam int GRAD_W = 12;
   localparam int SUM_W  = 25;
   localparam int ROOT_W = 16;
   localparam int BIT_W  = 3;

   // 4s >= 511^2 saturates
   localparam logic [SUM_W-1:0] SAT_LIMIT = 25'd65281;

   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_WIDTH  = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_HEIGHT = 1'b1;

   localparam logic OP_PIXEL = 1'b0;
   localparam logic OP_DRAIN = 1'b1;

   typedef enum logic [2:0] {
      S_IDLE,
      S_READ,
      S_GRAD,
      S_SQUARE,
      S_ROOT,
      S_DONE
   } state_type;

endpackage

FILE: hdl/sobel_edge_magnitude_rgb.sv
// Sobel edge magnitude, RGB, 3x3, one frame in raster order.
// req_*: one request per pixel (req_tuser = 0) or drain (req_tuser = 1).
//   req_tdata = {blue, green, red}, red in the low byte.
// rsp_*: rsp_tdata = {blue_edge, green_edge, red_edge}; rsp_tlast marks
//   the result of the frame's final pixel.
// csr_*: index 0 = frame width, 1 = frame height; always ready. A write
//   restarts the frame; write only while the block is idle.
// Results trail the pixel requests by one row plus one pixel; after the
// last pixel, each request, drain or pixel, returns one of the pending results.
// A request that produces a result goes through the accepting cycle, line
// store read, gradient, squares, the bit-serial square root (one result bit
// a cycle, all three channels in parallel), then the output load.
// A pixel with no result ends after the line store step, an ignored drain at once.
// The next request is accepted as soon as the output register is loaded,
// so one result can wait on a stalled receiver while the next computes;
// the block then holds in its final step until rsp_tready frees it.
// Reset: frame 640 x 480, counters and window cleared, no clearing pass;
// line store entries are only used after they were written.
module sobel_edge_magnitude_rgb #(
   parameter int MAX_WIDTH  = sem_pkg::MAX_WIDTH_DEF,
   parameter int MAX_HEIGHT = sem_pkg::MAX_HEIGHT_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   input  logic [sem_pkg::PIX_W-1:0]      req_tdata,  // red_in, green_in, blue_in
   input  logic                           req_tuser,  // opcode
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   output logic [sem_pkg::PIX_W-1:0]      rsp_tdata,  // red_edge, green_edge, blue_edge
   output logic                           rsp_tlast,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [sem_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [sem_pkg::CSR_DATA_W-1:0] csr_data
);
   import sem_pkg::*;

   localparam int CW   = $clog2(MAX_WIDTH);
   localparam int FW_W = $clog2(MAX_WIDTH + 1);
   localparam int RW   = $clog2(MAX_HEIGHT + 1);
   localparam int W_RST = (WIDTH_RST > MAX_WIDTH) ? MAX_WIDTH : WIDTH_RST;
   localparam int H_RST = (HEIGHT_RST > MAX_HEIGHT) ? MAX_HEIGHT : HEIGHT_RST;

   function automatic logic [31:0] clamp_size(input logic [CSR_DATA_W-1:0] v,
                                              input int mx);
      logic [31:0] x;
      x = 32'(v);
      if (x == 32'd0) x = 32'd1;
      if (x > 32'(mx)) x = 32'(mx);
      return x;
   endfunction

   state_type state_ff, state_in;

   logic [FW_W-1:0] fw_ff;
   logic [RW-1:0]   fh_ff;
   logic [CW-1:0]   col_ff;
   logic [RW-1:0]   row_ff;
   logic [CW-1:0]   ocol_ff;
   logic [RW-1:0]   orow_ff;
   logic            complete_ff;

   logic [PIX_W-1:0] upper_mem  [MAX_WIDTH];
   logic [PIX_W-1:0] middle_mem [MAX_WIDTH];
   logic [PIX_W-1:0] upper_rd_ff, middle_rd_ff;
   logic [PIX_W-1:0] win_ff [9];

   logic [PIX_W-1:0] pix_ff;
   logic             emit_ff;
   logic             drain_ff;

   logic signed [GRAD_W-1:0] gx_ff [NUM_CH];
   logic signed [GRAD_W-1:0] gy_ff [NUM_CH];
   logic [ROOT_W-1:0]        s_ff  [NUM_CH];
   logic                     sat_ff [NUM_CH];
   logic [CH_W-1:0]          k_ff  [NUM_CH];
   logic [BIT_W-1:0]         bit_ff;

   logic [PIX_W-1:0] rsp_data_ff;
   logic             rsp_valid_ff;
   logic             rsp_last_ff;

   logic mem_re, mem_we, accept, act_pixel, act_drain, load_out, csr_wr;
   logic emit_now, col_wrap, row_wrap, last_now;
   logic [8:0] mask;
   logic signed [GRAD_W-1:0] gx_c [NUM_CH];
   logic signed [GRAD_W-1:0] gy_c [NUM_CH];

   assign csr_ready  = 1'b1;
   assign csr_wr     = csr_valid && csr_ready;
   assign req_tready = (state_ff == S_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign act_pixel  = (req_tuser == OP_PIXEL) && !complete_ff;
   assign act_drain  = complete_ff;
   assign emit_now   = (row_ff >= RW'(2)) || ((row_ff == RW'(1)) && (col_ff != '0));
   assign col_wrap   = (FW_W'(col_ff) + FW_W'(1)) >= fw_ff;
   assign row_wrap   = (row_ff + RW'(1)) >= fh_ff;
   assign last_now   = (orow_ff + RW'(1) >= fh_ff) && (FW_W'(ocol_ff) + FW_W'(1) >= fw_ff);
   assign load_out   = (state_ff == S_DONE) && (!rsp_valid_ff || rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      mem_re   = 1'b0;
      mem_we   = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (accept && (act_pixel || act_drain)) begin
               mem_re   = 1'b1;
               state_in = S_READ;
            end
         end
         S_READ: begin
            mem_we   = 1'b1;
            state_in = emit_ff ? S_GRAD : S_IDLE;
         end
         S_GRAD:   state_in = S_SQUARE;
         S_SQUARE: state_in = S_ROOT;
         S_ROOT: begin
            if (bit_ff == '0) state_in = S_DONE;
         end
         S_DONE: begin
            if (load_out) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we) upper_mem[col_ff] <= middle_rd_ff;
      if (mem_re) upper_rd_ff <= upper_mem[col_ff];
   end

   always_ff @(posedge clock) begin
      if (mem_we) middle_mem[col_ff] <= pix_ff;
      if (mem_re) middle_rd_ff <= middle_mem[col_ff];
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         pix_ff   <= act_pixel ? req_tdata : '0;
         emit_ff  <= act_pixel ? emit_now : 1'b1;
         drain_ff <= !act_pixel;
      end
   end

   // frame position, window and configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         fw_ff       <= FW_W'(W_RST);
         fh_ff       <= RW'(H_RST);
         col_ff      <= '0;
         row_ff      <= '0;
         ocol_ff     <= '0;
         orow_ff     <= '0;
         complete_ff <= 1'b0;
         for (int i = 0; i < 9; i++) win_ff[i] <= '0;
      end else if (csr_wr) begin
         unique case (csr_index)
            CSR_FRAME_WIDTH:  fw_ff <= FW_W'(clamp_size(csr_data, MAX_WIDTH));
            CSR_FRAME_HEIGHT: fh_ff <= RW'(clamp_size(csr_data, MAX_HEIGHT));
            default: ;
         endcase
         col_ff      <= '0;
         row_ff      <= '0;
         ocol_ff     <= '0;
         orow_ff     <= '0;
         complete_ff <= 1'b0;
         for (int i = 0; i < 9; i++) win_ff[i] <= '0;
      end else if (state_ff == S_READ) begin
         for (int r = 0; r < 3; r++) begin
            win_ff[r*3]   <= win_ff[r*3+1];
            win_ff[r*3+1] <= win_ff[r*3+2];
         end
         win_ff[2] <= upper_rd_ff;
         win_ff[5] <= middle_rd_ff;
         win_ff[8] <= pix_ff;
         col_ff <= col_wrap ? '0 : col_ff + CW'(1);
         if (col_wrap && !drain_ff) begin
            if (row_wrap) begin
               row_ff      <= '0;
               complete_ff <= 1'b1;
            end else begin
               row_ff <= row_ff + RW'(1);
            end
         end
      end else if (load_out) begin
         if (drain_ff && last_now) begin
            col_ff      <= '0;
            row_ff      <= '0;
            ocol_ff     <= '0;
            orow_ff     <= '0;
            complete_ff <= 1'b0;
            for (int i = 0; i < 9; i++) win_ff[i] <= '0;
         end else if (FW_W'(ocol_ff) + FW_W'(1) >= fw_ff) begin
            ocol_ff <= '0;
            orow_ff <= orow_ff + RW'(1);
         end else begin
            ocol_ff <= ocol_ff + CW'(1);
         end
      end
   end

   always_comb begin
      logic [9:0] pos_x, neg_x, pos_y, neg_y;
      logic [CH_W-1:0] p [9];
      for (int i = 0; i < 9; i++) begin
         mask[i] = 1'b1;
         if ((i / 3 == 0) && (orow_ff == '0)) mask[i] = 1'b0;
         if ((i / 3 == 2) && (orow_ff + RW'(1) >= fh_ff)) mask[i] = 1'b0;
         if ((i % 3 == 0) && (ocol_ff == '0)) mask[i] = 1'b0;
         if ((i % 3 == 2) && (FW_W'(ocol_ff) + FW_W'(1) >= fw_ff)) mask[i] = 1'b0;
      end
      for (int ch = 0; ch < NUM_CH; ch++) begin
         for (int i = 0; i < 9; i++) begin
            p[i] = mask[i] ? win_ff[i][ch*CH_W +: CH_W] : '0;
         end
         pos_x = 10'(p[2]) + {1'b0, p[5], 1'b0} + 10'(p[8]);
         neg_x = 10'(p[0]) + {1'b0, p[3], 1'b0} + 10'(p[6]);
         pos_y = 10'(p[6]) + {1'b0, p[7], 1'b0} + 10'(p[8]);
         neg_y = 10'(p[0]) + {1'b0, p[1], 1'b0} + 10'(p[2]);
         gx_c[ch] = $signed({2'b00, pos_x}) - $signed({2'b00, neg_x});
         gy_c[ch] = $signed({2'b00, pos_y}) - $signed({2'b00, neg_y});
      end
   end

   // gradient, squares, then bit-serial rounded root
   always_ff @(posedge clock) begin
      logic [SUM_W-1:0] s;
      logic [CH_W-1:0]  trial;
      logic [ROOT_W-1:0] prod;
      if (state_ff == S_GRAD) begin
         for (int ch = 0; ch < NUM_CH; ch++) begin
            gx_ff[ch] <= gx_c[ch];
            gy_ff[ch] <= gy_c[ch];
         end
      end
      if (state_ff == S_SQUARE) begin
         for (int ch = 0; ch < NUM_CH; ch++) begin
            s = SUM_W'($unsigned(SUM_W'(gx_ff[ch]) * SUM_W'(gx_ff[ch])))
              + SUM_W'($unsigned(SUM_W'(gy_ff[ch]) * SUM_W'(gy_ff[ch])));
            sat_ff[ch] <= (s >= SAT_LIMIT);
            s_ff[ch]   <= s[ROOT_W-1:0];
            k_ff[ch]   <= '0;
         end
         bit_ff <= BIT_W'(CH_W - 1);
      end
      if (state_ff == S_ROOT) begin
         for (int ch = 0; ch < NUM_CH; ch++) begin
            trial = k_ff[ch] | (CH_W'(1) << bit_ff);
            prod  = ROOT_W'(trial) * ROOT_W'(trial - CH_W'(1));
            if (prod < s_ff[ch]) k_ff[ch] <= trial;
         end
         bit_ff <= bit_ff - BIT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (load_out) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load_out) begin
         for (int ch = 0; ch < NUM_CH; ch++) begin
            rsp_data_ff[ch*CH_W +: CH_W] <= sat_ff[ch] ? '1 : k_ff[ch];
         end
         rsp_last_ff <= drain_ff && last_now;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

   a_mem_port: assert property (@(posedge clock) disable iff (reset)
      !(mem_re && mem_we)) else $error("line store read and write collide");

   a_col_range: assert property (@(posedge clock) disable iff (reset)
      FW_W'(col_ff) < fw_ff) else $error("input column beyond frame width");

   a_row_range: assert property (@(posedge clock) disable iff (reset)
      row_ff < fh_ff) else $error("input row beyond frame height");

   a_last_drain: assert property (@(posedge clock) disable iff (reset)
      (load_out && drain_ff && last_now) |-> complete_ff)
      else $error("final result before frame input complete");

endmodule

FILE: tb/testbench.sv
module testbench;
   import sem_pkg::*;

   localparam int LIMIT = 1000000;
   localparam int SETTLE = 30;

   typedef struct {
      logic [PIX_W-1:0] edges;
      logic             last;
   } edge_result_type;

   class edge_scoreboard;
      int unsigned width, height;
      logic [PIX_W-1:0] upper_row [MAX_WIDTH_DEF];
      logic [PIX_W-1:0] middle_row [MAX_WIDTH_DEF];
      logic [PIX_W-1:0] win [9];
      int unsigned row, col, out_idx;
      bit complete;
      edge_result_type expected_edges [$];
      int fails;

      function new();
         foreach (upper_row[i]) begin
            upper_row[i] = '0;
            middle_row[i] = '0;
         end
         width = WIDTH_RST;
         height = HEIGHT_RST;
         fails = 0;
         restart();
      endfunction

      function void restart();
         row = 0;
         col = 0;
         out_idx = 0;
         complete = 0;
         foreach (win[i]) win[i] = '0;
      endfunction

      function void configure(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] val);
         int unsigned v;
         v = val;
         if (v < 1) v = 1;
         if (idx == CSR_FRAME_WIDTH) begin
            width = (v > MAX_WIDTH_DEF) ? MAX_WIDTH_DEF : v;
         end else begin
            height = (v > MAX_HEIGHT_DEF) ? MAX_HEIGHT_DEF : v;
         end
         restart();
      endfunction

      function bit shift_column(logic [PIX_W-1:0] pix);
         logic [PIX_W-1:0] top, md;
         top = upper_row[col];
         md = middle_row[col];
         upper_row[col] = md;
         middle_row[col] = pix;
         for (int r = 0; r < 3; r++) begin
            win[r*3] = win[r*3+1];
            win[r*3+1] = win[r*3+2];
         end
         win[2] = top;
         win[5] = md;
         win[8] = pix;
         if (col + 1 >= width) begin
            col = 0;
            return 1;
         end
         col = col + 1;
         return 0;
      endfunction

      function int unsigned round_root(int unsigned s);
         int unsigned q, k;
         q = 4 * s;
         k = 0;
         if (q >= 511 * 511) return 255;
         while ((2*k+1) * (2*k+1) <= q) k++;
         return k;
      endfunction

      function logic [PIX_W-1:0] magnitude();
         int kx [9] = '{-1, 0, 1, -2, 0, 2, -1, 0, 1};
         int ky [9] = '{-1, -2, -1, 0, 0, 0, 1, 2, 1};
         int gx [3], gy [3];
         int unsigned orow, ocol;
         logic [PIX_W-1:0] res;
         orow = out_idx / width;
         ocol = out_idx % width;
         for (int ch = 0; ch < 3; ch++) begin
            gx[ch] = 0;
            gy[ch] = 0;
         end
         for (int r = 0; r < 3; r++) begin
            if (r == 0 && orow == 0) continue;
            if (r == 2 && orow + 1 >= height) continue;
            for (int c = 0; c < 3; c++) begin
               if (c == 0 && ocol == 0) continue;
               if (c == 2 && ocol + 1 >= width) continue;
               for (int ch = 0; ch < 3; ch++) begin
                  int v;
                  v = win[r*3+c][ch*CH_W +: CH_W];
                  gx[ch] += v * kx[r*3+c];
                  gy[ch] += v * ky[r*3+c];
               end
            end
         end
         for (int ch = 0; ch < 3; ch++)
            res[ch*CH_W +: CH_W] = CH_W'(round_root(gx[ch]*gx[ch] + gy[ch]*gy[ch]));
         return res;
      endfunction

      // returns 0 when the request is ignored
      function bit note_request(logic op, logic [PIX_W-1:0] pix);
         edge_result_type e;
         bit emit;
         if (op == OP_PIXEL && !complete) begin
            emit = row >= 2 || (row == 1 && col >= 1);
            if (shift_column(pix)) begin
               row++;
               if (row >= height) begin
                  row = 0;
                  complete = 1;
               end
            end
            if (emit) begin
               e.edges = magnitude();
               e.last = 0;
               out_idx++;
               expected_edges.push_back(e);
            end
            return 1;
         end
         if (!complete) return 0;
         void'(shift_column('0));
         e.edges = magnitude();
         if (out_idx + 1 >= width * height) begin
            e.last = 1;
            restart();
         end else begin
            e.last = 0;
            out_idx++;
         end
         expected_edges.push_back(e);
         return 1;
      endfunction

      function void check_result(logic [PIX_W-1:0] edges, logic last);
         edge_result_type e;
         if (expected_edges.size() == 0) begin
            $display("%0t: unexpected result edges=%h last=%b", $time, edges, last);
            fails++;
            return;
         end
         e = expected_edges.pop_front();
         if (e.edges !== edges) begin
            $display("%0t: edges expected %h actual %h", $time, e.edges, edges);
            fails++;
         end
         if (e.last !== last) begin
            $display("%0t: last expected %b actual %b", $time, e.last, last);
            fails++;
         end
      endfunction

      function int pending();
         return expected_edges.size();
      endfunction
   endclass

   logic clock = 0;
   logic reset = 1;
   logic req_tvalid = 0;
   logic req_tready;
   logic [PIX_W-1:0] req_tdata = '0;
   logic req_tuser = 0;
   logic rsp_tvalid;
   logic rsp_tready = 0;
   logic [PIX_W-1:0] rsp_tdata;
   logic rsp_tlast;
   logic csr_valid = 0;
   logic csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_data = '0;

   edge_scoreboard sb = new();
   int send_idle_pct = 0;
   int recv_stall_pct = 0;
   int cycles = 0;
   int counted = 0;

   sobel_edge_magnitude_rgb uut (.*);

   initial begin
      forever #6 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > LIMIT) begin
         $display("Verification failed");
         $finish;
      end
      if (!reset && rsp_tvalid && rsp_tready) sb.check_result(rsp_tdata, rsp_tlast);
   end

   always @(negedge clock) rsp_tready = ($urandom_range(99) >= recv_stall_pct);

   task automatic send(logic op, logic [PIX_W-1:0] pix);
      if ($urandom_range(99) < send_idle_pct) begin
         req_tvalid = 0;
         repeat ($urandom_range(1, 4)) @(negedge clock);
      end
      req_tvalid = 1;
      req_tuser = op;
      req_tdata = pix;
      do @(posedge clock); while (!req_tready);
      if (sb.note_request(op, pix)) counted++;
      @(negedge clock);
   endtask

   task automatic drain_all();
      req_tvalid = 0;
      while (sb.pending() > 0) @(negedge clock);
      repeat (SETTLE) @(negedge clock);
   endtask

   task automatic write_csr(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] val);
      csr_valid = 1;
      csr_index = idx;
      csr_data = val;
      do @(posedge clock); while (!csr_ready);
      sb.configure(idx, val);
      @(negedge clock);
      csr_valid = 0;
   endtask

   function automatic logic [PIX_W-1:0] random_pixel();
      logic [PIX_W-1:0] p;
      for (int ch = 0; ch < 3; ch++) begin
         case ($urandom_range(3))
            0: p[ch*CH_W +: CH_W] = 8'h00;
            1: p[ch*CH_W +: CH_W] = 8'hff;
            default: p[ch*CH_W +: CH_W] = CH_W'($urandom_range(255));
         endcase
      end
      return p;
   endfunction

   task automatic run_frame(int w, int h);
      int n;
      drain_all();
      write_csr(CSR_FRAME_WIDTH, CSR_DATA_W'(w));
      write_csr(CSR_FRAME_HEIGHT, CSR_DATA_W'(h));
      if ($urandom_range(9) == 0) send(OP_DRAIN, random_pixel());
      for (int i = 0; i < sb.width * sb.height; i++) begin
         send(OP_PIXEL, random_pixel());
         if ($urandom_range(99) == 0) drain_all();
      end
      n = (sb.width * sb.height < sb.width + 1) ? sb.width * sb.height : sb.width + 1;
      for (int i = 0; i < n; i++)
         send($urandom_range(4) == 0 ? OP_PIXEL : OP_DRAIN, random_pixel());
      if ($urandom_range(9) == 0) send(OP_DRAIN, random_pixel());
   endtask

   initial begin
      logic [PIX_W-1:0] pat [9] = '{24'hffffff, 24'h000000, 24'hffffff,
                                    24'h000000, 24'hff00ff, 24'h000000,
                                    24'h00ff00, 24'hffffff, 24'h123456};
      int frame_no;
      repeat (8) @(negedge clock);
      reset = 0;
      write_csr(CSR_FRAME_WIDTH, CSR_DATA_W'(3));
      write_csr(CSR_FRAME_HEIGHT, CSR_DATA_W'(3));
      send(OP_DRAIN, 24'hffffff);
      foreach (pat[i]) send(OP_PIXEL, pat[i]);
      send(OP_PIXEL, 24'hffffff);
      repeat (3) send(OP_DRAIN, '0);
      send(OP_DRAIN, '0);
      drain_all();
      write_csr(CSR_FRAME_WIDTH, CSR_DATA_W'(1));
      write_csr(CSR_FRAME_HEIGHT, CSR_DATA_W'(1));
      send(OP_PIXEL, 24'hffffff);
      send(OP_DRAIN, '0);
      run_frame(3, 0);
      run_frame(0, 2047);
      run_frame(2, 1);
      frame_no = 0;
      while (counted < 1300) begin
         case (frame_no % 4)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 64; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 64; end
            default: begin send_idle_pct = 35; recv_stall_pct = 35; end
         endcase
         if (frame_no % 7 == 3) run_frame(40, 3);
         else run_frame($urandom_range(1, 9), $urandom_range(1, 6));
         frame_no++;
      end
      drain_all();
      if (sb.fails == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end
endmodule

FILE: filelist.f
hdl/sem_pkg.sv
hdl/sobel_edge_magnitude_rgb.sv
tb/testbench.sv
